// ----- design/vfcp_pkg.sv -----
// shared types and constants of the voxel file chunk parser
`default_nettype none
package vfcp_pkg;

   // little-endian chunk tags, first file byte in bits 7:0
   localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
   localparam logic [31:0] TAG_MAIN = 32'h4E49_414D;
   localparam logic [31:0] TAG_XYZI = 32'h495A_5958;
   localparam logic [31:0] TAG_RGBA = 32'h4142_4752;
   localparam logic [31:0] TAG_MATT = 32'h5454_414D;
   localparam logic [31:0] TAG_PACK = 32'h4B43_4150;
   localparam logic [31:0] TAG_SIZE = 32'h455A_4953;

   localparam logic [4:0] SHORT_LIMIT   = 5'd20;
   localparam logic [7:0] PALETTE_WORDS = 8'd254;

   // record kinds
   localparam logic [2:0] KIND_VOXEL    = 3'd0;
   localparam logic [2:0] KIND_PALETTE  = 3'd1;
   localparam logic [2:0] KIND_MAT_ID   = 3'd2;
   localparam logic [2:0] KIND_MAT_PROP = 3'd5;
   localparam logic [2:0] KIND_MAT_FLAG = 3'd6;
   localparam logic [2:0] KIND_STATUS   = 3'd7;

   // status codes
   localparam logic [31:0] ST_DONE      = 32'd0;
   localparam logic [31:0] ST_NOT_VOX   = 32'd1;
   localparam logic [31:0] ST_NO_MAIN   = 32'd2;
   localparam logic [31:0] ST_VER_WARN  = 32'd3;
   localparam logic [31:0] ST_EXT_WARN  = 32'd4;

   // chunk kinds
   localparam logic [1:0] CK_SKIP = 2'd0;
   localparam logic [1:0] CK_XYZI = 2'd1;
   localparam logic [1:0] CK_RGBA = 2'd2;
   localparam logic [1:0] CK_MATT = 2'd3;

   typedef enum logic [10:0] {
      PH_MAGIC      = 11'b000_0000_0001,
      PH_VERSION    = 11'b000_0000_0010,
      PH_MAIN_ID    = 11'b000_0000_0100,
      PH_MAIN_SIZE  = 11'b000_0000_1000,
      PH_MAIN_KIDS  = 11'b000_0001_0000,
      PH_MAIN_SKIP  = 11'b000_0010_0000,
      PH_CH_ID      = 11'b000_0100_0000,
      PH_CH_SIZE    = 11'b000_1000_0000,
      PH_CH_KIDS    = 11'b001_0000_0000,
      PH_CH_CONTENT = 11'b010_0000_0000,
      PH_HALT       = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [7:0]  voxel_x;
      logic [7:0]  voxel_y;
      logic [7:0]  voxel_z;
      logic [7:0]  color_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [31:0] data_word;
      logic [2:0]  property_code;
      logic        last_of_run;
   } record_type;

   typedef struct packed {
      logic [1:0] valid;
      record_type rec1;
      record_type rec0;
   } rec_pair_type;

   typedef struct packed {
      logic [2:0] count;
      logic       full;
   } fifo_status_type;

endpackage
`default_nettype wire

// ----- design/vfcp_parser.sv -----
// byte-at-a-time chunk parser state and result generation
`default_nettype none
module vfcp_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  end_of_file,
   input  wire logic [30:0]           max_version,
   output vfcp_pkg::rec_pair_type     results
);

   vfcp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  sec_ff, sec_in;
   logic [31:0] wasm_ff, wasm_in;
   logic [1:0]  ck_ff, ck_in;
   logic [31:0] crem_ff, crem_in;
   logic [31:0] vrem_ff, vrem_in;
   logic [1:0]  wbi_ff, wbi_in;
   logic [7:0]  pal_ff, pal_in;
   logic [6:0]  pmask_ff, pmask_in;
   logic [2:0]  ppos_ff, ppos_in;
   logic [4:0]  tot_ff, tot_in;
   logic        extw_ff, extw_in;
   logic        err_ff, err_in;
   logic        verh_ff, verh_in;
   logic        mbad_ff, mbad_in;
   logic [2:0]  wd_ff, wd_in;

   logic [31:0] gword, cword;
   logic [6:0]  avail;
   logic        found;
   logic [2:0]  pidx;
   logic [3:0]  cv;
   vfcp_pkg::record_type c0, c1, c2, c3;

   assign gword = wasm_ff | ({24'h0, in_byte} << {sec_ff, 3'b000});
   assign cword = wasm_ff | ({24'h0, in_byte} << {wbi_ff, 3'b000});

   // next selected property at or after the current position
   always_comb begin
      found = 1'b0;
      pidx  = 3'd0;
      for (int p = 0; p < 7; p++) begin
         avail[p] = pmask_ff[p] && (3'(p) >= ppos_ff);
      end
      for (int p = 6; p >= 0; p--) begin
         if (avail[p]) begin
            found = 1'b1;
            pidx  = 3'(p);
         end
      end
   end

   always_comb begin
      logic err_pre;
      err_pre  = err_ff;
      phase_in = phase_ff;
      sec_in   = sec_ff;
      wasm_in  = wasm_ff;
      ck_in    = ck_ff;
      crem_in  = crem_ff;
      vrem_in  = vrem_ff;
      wbi_in   = wbi_ff;
      pal_in   = pal_ff;
      pmask_in = pmask_ff;
      ppos_in  = ppos_ff;
      extw_in  = extw_ff;
      verh_in  = verh_ff;
      mbad_in  = mbad_ff;
      wd_in    = wd_ff;
      cv = 4'b0000;
      c0 = '0; c1 = '0; c2 = '0; c3 = '0;
      c0.record_kind = vfcp_pkg::KIND_STATUS;
      c0.data_word   = vfcp_pkg::ST_VER_WARN;
      c1.record_kind = vfcp_pkg::KIND_STATUS;
      c1.data_word   = vfcp_pkg::ST_NO_MAIN;
      c3.record_kind = vfcp_pkg::KIND_STATUS;

      // held-back header verdicts once the file is known not to be short
      if (tot_ff == vfcp_pkg::SHORT_LIMIT && !err_ff) begin
         cv[0] = verh_ff;
         if (mbad_ff) begin
            cv[1]    = 1'b1;
            err_pre  = 1'b1;
            phase_in = vfcp_pkg::PH_HALT;
         end
      end
      tot_in = (tot_ff <= vfcp_pkg::SHORT_LIMIT) ? tot_ff + 5'd1 : tot_ff;
      err_in = err_pre;

      if (!err_pre) begin
         unique case (phase_ff)
            vfcp_pkg::PH_MAGIC, vfcp_pkg::PH_VERSION, vfcp_pkg::PH_MAIN_ID,
            vfcp_pkg::PH_MAIN_SIZE, vfcp_pkg::PH_MAIN_KIDS, vfcp_pkg::PH_CH_ID,
            vfcp_pkg::PH_CH_SIZE, vfcp_pkg::PH_CH_KIDS: begin
               sec_in  = sec_ff + 2'd1;
               wasm_in = gword;
               if (sec_ff == 2'd3) begin
                  wasm_in = '0;
                  unique case (phase_ff)
                     vfcp_pkg::PH_MAGIC: begin
                        if (gword != vfcp_pkg::TAG_VOX) begin
                           cv[2]          = 1'b1;
                           c2.record_kind = vfcp_pkg::KIND_STATUS;
                           c2.data_word   = vfcp_pkg::ST_NOT_VOX;
                           err_in         = 1'b1;
                           phase_in       = vfcp_pkg::PH_HALT;
                        end else begin
                           phase_in = vfcp_pkg::PH_VERSION;
                        end
                     end
                     vfcp_pkg::PH_VERSION: begin
                        verh_in  = !gword[31] && (gword[30:0] > max_version);
                        phase_in = vfcp_pkg::PH_MAIN_ID;
                     end
                     vfcp_pkg::PH_MAIN_ID: begin
                        mbad_in  = (gword != vfcp_pkg::TAG_MAIN);
                        phase_in = vfcp_pkg::PH_MAIN_SIZE;
                     end
                     vfcp_pkg::PH_MAIN_SIZE: begin
                        crem_in  = gword;
                        phase_in = vfcp_pkg::PH_MAIN_KIDS;
                     end
                     vfcp_pkg::PH_MAIN_KIDS: begin
                        phase_in = (crem_ff != 32'd0) ? vfcp_pkg::PH_MAIN_SKIP
                                                      : vfcp_pkg::PH_CH_ID;
                     end
                     vfcp_pkg::PH_CH_ID: begin
                        if (gword == vfcp_pkg::TAG_XYZI) begin
                           ck_in = vfcp_pkg::CK_XYZI;
                        end else if (gword == vfcp_pkg::TAG_RGBA) begin
                           ck_in = vfcp_pkg::CK_RGBA;
                        end else if (gword == vfcp_pkg::TAG_MATT) begin
                           ck_in = vfcp_pkg::CK_MATT;
                        end else begin
                           ck_in = vfcp_pkg::CK_SKIP;
                           if (gword != vfcp_pkg::TAG_PACK && gword != vfcp_pkg::TAG_SIZE
                               && !extw_ff) begin
                              cv[2]          = 1'b1;
                              c2.record_kind = vfcp_pkg::KIND_STATUS;
                              c2.data_word   = vfcp_pkg::ST_EXT_WARN;
                              extw_in        = 1'b1;
                           end
                        end
                        phase_in = vfcp_pkg::PH_CH_SIZE;
                     end
                     vfcp_pkg::PH_CH_SIZE: begin
                        crem_in  = gword;
                        phase_in = vfcp_pkg::PH_CH_KIDS;
                     end
                     default: begin
                        wbi_in   = '0;
                        wd_in    = '0;
                        pal_in   = '0;
                        pmask_in = '0;
                        ppos_in  = '0;
                        vrem_in  = '0;
                        phase_in = (crem_ff != 32'd0) ? vfcp_pkg::PH_CH_CONTENT
                                                      : vfcp_pkg::PH_CH_ID;
                     end
                  endcase
               end
            end
            vfcp_pkg::PH_MAIN_SKIP: begin
               crem_in = crem_ff - 32'd1;
               if (crem_ff == 32'd1) begin
                  phase_in = vfcp_pkg::PH_CH_ID;
               end
            end
            vfcp_pkg::PH_CH_CONTENT: begin
               crem_in = crem_ff - 32'd1;
               wbi_in  = wbi_ff + 2'd1;
               wasm_in = cword;
               if (wbi_ff == 2'd3) begin
                  wasm_in = '0;
                  unique case (ck_ff)
                     vfcp_pkg::CK_XYZI: begin
                        if (wd_ff == 3'd0) begin
                           vrem_in = cword[31] ? 32'd0 : cword;
                           wd_in   = 3'd1;
                        end else if (vrem_ff != 32'd0) begin
                           cv[2]          = 1'b1;
                           c2.record_kind = vfcp_pkg::KIND_VOXEL;
                           c2.voxel_x     = cword[7:0];
                           c2.voxel_y     = cword[15:8];
                           c2.voxel_z     = cword[23:16];
                           c2.color_index = cword[31:24];
                           vrem_in        = vrem_ff - 32'd1;
                        end
                     end
                     vfcp_pkg::CK_RGBA: begin
                        if (pal_ff < vfcp_pkg::PALETTE_WORDS) begin
                           pal_in         = pal_ff + 8'd1;
                           cv[2]          = 1'b1;
                           c2.record_kind = vfcp_pkg::KIND_PALETTE;
                           c2.color_index = pal_ff + 8'd1;
                           c2.red         = cword[7:0];
                           c2.green       = cword[15:8];
                           c2.blue        = cword[23:16];
                           c2.alpha       = cword[31:24];
                        end
                     end
                     vfcp_pkg::CK_MATT: begin
                        if (wd_ff < 3'd3) begin
                           cv[2]          = 1'b1;
                           c2.record_kind = vfcp_pkg::KIND_MAT_ID + wd_ff;
                           c2.data_word   = cword;
                           wd_in          = wd_ff + 3'd1;
                        end else if (wd_ff == 3'd3) begin
                           pmask_in       = cword[6:0];
                           ppos_in        = '0;
                           cv[2]          = 1'b1;
                           c2.record_kind = vfcp_pkg::KIND_MAT_FLAG;
                           c2.data_word   = {31'd0, cword[7]};
                           wd_in          = 3'd4;
                        end else if (found) begin
                           cv[2]            = 1'b1;
                           c2.record_kind   = vfcp_pkg::KIND_MAT_PROP;
                           c2.data_word     = cword;
                           c2.property_code = pidx;
                           ppos_in          = pidx + 3'd1;
                        end else begin
                           ppos_in = 3'd7;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (crem_ff == 32'd1) begin
                  wasm_in  = '0;
                  wbi_in   = '0;
                  sec_in   = '0;
                  phase_in = vfcp_pkg::PH_CH_ID;
               end
            end
            default: begin
            end
         endcase
      end

      if (end_of_file) begin
         if (!err_in) begin
            cv[3]        = 1'b1;
            c3.data_word = (tot_in <= vfcp_pkg::SHORT_LIMIT) ? vfcp_pkg::ST_NOT_VOX
                                                             : vfcp_pkg::ST_DONE;
         end
         phase_in = vfcp_pkg::PH_MAGIC;
         sec_in   = '0;
         wasm_in  = '0;
         ck_in    = vfcp_pkg::CK_SKIP;
         crem_in  = '0;
         vrem_in  = '0;
         wbi_in   = '0;
         pal_in   = '0;
         pmask_in = '0;
         ppos_in  = '0;
         tot_in   = '0;
         extw_in  = 1'b0;
         err_in   = 1'b0;
         verh_in  = 1'b0;
         mbad_in  = 1'b0;
         wd_in    = '0;
      end
   end

   // pack up to two candidates in order, mark the final one
   always_comb begin
      logic [1:0] n;
      vfcp_pkg::record_type cs [4];
      cs[0] = c0; cs[1] = c1; cs[2] = c2; cs[3] = c3;
      n = 2'd0;
      results = '0;
      for (int i = 0; i < 4; i++) begin
         if (cv[i]) begin
            if (n == 2'd0) begin
               results.rec0 = cs[i];
            end else begin
               results.rec1 = cs[i];
            end
            n = (n == 2'd2) ? n : n + 2'd1;
         end
      end
      unique case (n)
         2'd1: begin
            results.valid            = 2'b01;
            results.rec0.last_of_run = 1'b1;
         end
         2'd2: begin
            results.valid            = 2'b11;
            results.rec1.last_of_run = 1'b1;
         end
         default: begin
            results.valid = 2'b00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= vfcp_pkg::PH_MAGIC;
         sec_ff   <= '0;
         wasm_ff  <= '0;
         ck_ff    <= vfcp_pkg::CK_SKIP;
         crem_ff  <= '0;
         vrem_ff  <= '0;
         wbi_ff   <= '0;
         pal_ff   <= '0;
         pmask_ff <= '0;
         ppos_ff  <= '0;
         tot_ff   <= '0;
         extw_ff  <= 1'b0;
         err_ff   <= 1'b0;
         verh_ff  <= 1'b0;
         mbad_ff  <= 1'b0;
         wd_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         sec_ff   <= sec_in;
         wasm_ff  <= wasm_in;
         ck_ff    <= ck_in;
         crem_ff  <= crem_in;
         vrem_ff  <= vrem_in;
         wbi_ff   <= wbi_in;
         pal_ff   <= pal_in;
         pmask_ff <= pmask_in;
         ppos_ff  <= ppos_in;
         tot_ff   <= tot_in;
         extw_ff  <= extw_in;
         err_ff   <= err_in;
         verh_ff  <= verh_in;
         mbad_ff  <= mbad_in;
         wd_ff    <= wd_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/vfcp_result_fifo.sv -----
// four-entry result queue, two writes and one read per cycle
`default_nettype none
module vfcp_result_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire vfcp_pkg::rec_pair_type  wr_pair,
   input  wire logic                    pop,
   output vfcp_pkg::record_type         rd_rec,
   output vfcp_pkg::fifo_status_type    status
);

   vfcp_pkg::record_type mem_ff [4];
   logic [1:0] wp_ff, wp_in;
   logic [1:0] rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] nwr;
   logic       do_pop;

   assign nwr    = push ? ({1'b0, wr_pair.valid[0]} + {1'b0, wr_pair.valid[1]}) : 2'd0;
   assign do_pop = pop && (cnt_ff != 3'd0);
   assign wp_in  = wp_ff + nwr;
   assign rp_in  = rp_ff + {1'b0, do_pop};
   assign cnt_in = cnt_ff + {1'b0, nwr} - {2'b00, do_pop};

   assign rd_rec       = mem_ff[rp_ff];
   assign status.count = cnt_ff;
   assign status.full  = (cnt_ff > 3'd2);

   always_ff @(posedge clock) begin
      if (push && wr_pair.valid[0]) begin
         mem_ff[wp_ff] <= wr_pair.rec0;
      end
      if (push && wr_pair.valid[1]) begin
         mem_ff[wp_ff + 2'd1] <= wr_pair.rec1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/voxel_file_chunk_parser_unit.sv -----
// top level of the voxel file chunk parser
//
// takes one file byte per request and returns 0, 1 or 2 records for it in file order:
// voxel, palette, material and status records; a byte can enter every clock while the
// result queue has room for two records; results leave one per cycle from a four-entry
// queue while rsp_stall is low, so the sustained rate is one byte per cycle when bytes
// average at most one record, and otherwise the one-record-per-cycle output port sets it;
// records are queued, so a byte's first record reaches rsp_ after the records ahead of it
`default_nettype none
module voxel_file_chunk_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte requests
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_file,
   // result records
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_record_kind,
   output logic [7:0]       rsp_voxel_x,
   output logic [7:0]       rsp_voxel_y,
   output logic [7:0]       rsp_voxel_z,
   output logic [7:0]       rsp_color_index,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic [31:0]      rsp_data_word,
   output logic [2:0]       rsp_property_code,
   output logic             rsp_last_of_run,
   // version limit register
   input  wire logic        csr_wr_en,
   input  wire logic [30:0] csr_wr_data
);

   logic [30:0] maxver_ff;
   logic        req_accept;
   logic        rsp_accept;
   vfcp_pkg::rec_pair_type    pair;
   vfcp_pkg::record_type      head;
   vfcp_pkg::fifo_status_type fstat;

   // version limit, resets to 150
   always_ff @(posedge clock) begin
      if (reset) begin
         maxver_ff <= 31'd150;
      end else if (csr_wr_en) begin
         maxver_ff <= csr_wr_data;
      end
   end

   // a byte needs room for two records
   assign req_stall  = fstat.full;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (fstat.count != 3'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   vfcp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .in_byte     (req_in_byte),
      .end_of_file (req_end_of_file),
      .max_version (maxver_ff),
      .results     (pair)
   );

   vfcp_result_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept),
      .wr_pair (pair),
      .pop     (rsp_accept),
      .rd_rec  (head),
      .status  (fstat)
   );

   // output fields straight from the queue head
   assign rsp_record_kind   = head.record_kind;
   assign rsp_voxel_x       = head.voxel_x;
   assign rsp_voxel_y       = head.voxel_y;
   assign rsp_voxel_z       = head.voxel_z;
   assign rsp_color_index   = head.color_index;
   assign rsp_red           = head.red;
   assign rsp_green         = head.green;
   assign rsp_blue          = head.blue;
   assign rsp_alpha         = head.alpha;
   assign rsp_data_word     = head.data_word;
   assign rsp_property_code = head.property_code;
   assign rsp_last_of_run   = head.last_of_run;

   // queue never overfills
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      fstat.count <= 3'd4)
      else $error("result queue overflow");

   // a queue that was empty and took nothing stays empty
   a_empty_holds : assert property (@(posedge clock) disable iff (reset)
      (fstat.count == 3'd0 && !req_accept) |=> !rsp_valid)
      else $error("result appeared without a request");

   // a taken record leaves the queue unless a request refilled it
   a_pop_counts : assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !req_accept) |=> fstat.count == $past(fstat.count) - 3'd1)
      else $error("queue count off after a pop");

endmodule
`default_nettype wire
